// ----- hw/rtl/mts_pkg.sv -----
// ----------------------------------------------------------------------------
// mts_pkg
// Types and constants shared by the timer scheduler modules.
// ----------------------------------------------------------------------------
package mts_pkg;

	localparam int TIMERS_DEF = 16;
	localparam int TW = 64;

	localparam logic [2:0] OP_TICK   = 3'd0;
	localparam logic [2:0] OP_ADD    = 3'd1;
	localparam logic [2:0] OP_CHANGE = 3'd2;
	localparam logic [2:0] OP_AHEAD  = 3'd3;
	localparam logic [2:0] OP_DELAY  = 3'd4;
	localparam logic [2:0] OP_CANCEL = 3'd5;
	localparam logic [2:0] OP_EXPIRE = 3'd6;
	localparam logic [2:0] OP_RSVD   = 3'd7;

	localparam logic [2:0] ST_DONE    = 3'd0;
	localparam logic [2:0] ST_NOSLOT  = 3'd1;
	localparam logic [2:0] ST_FULL    = 3'd2;
	localparam logic [2:0] ST_EXPIRED = 3'd3;
	localparam logic [2:0] ST_NONE    = 3'd4;

	typedef struct packed {
		logic [2:0]    op;
		logic [3:0]    slot;
		logic [TW-1:0] time_amount;
		logic [TW-1:0] reload_interval;
		logic [TW-1:0] now_us;
	} req_t;

	typedef struct packed {
		logic [2:0]    status;
		logic [3:0]    slot_out;
		logic          rearmed;
		logic [TW-1:0] next_deadline;
		logic [31:0]   expire_total;
		logic          last;
	} rsp_t;

	// saturating 64-bit add
	function automatic logic [TW-1:0] sat_add(input logic [TW-1:0] a, input logic [TW-1:0] b);
		logic [TW:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[TW] ? {TW{1'b1}} : s[TW-1:0];
	endfunction

endpackage

// ----- hw/rtl/mts_ram.sv -----
// ----------------------------------------------------------------------------
// mts_ram
// Generic single-port-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mts_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ----- hw/rtl/multi_timer_scheduler_core.sv -----
// ----------------------------------------------------------------------------
// multi_timer_scheduler_core
// Timer slot table held in deadline and period RAMs, with a sequencer that
// scans slots for the earliest deadline and applies each request.
// ----------------------------------------------------------------------------
//  channel | signals                  | handshake
//  request | start, busy, req         | taken when start && !busy
//  result  | rsp_valid, rsp           | one-cycle strobe, no backpressure
//
// A request other than a tick goes from accept to result through slot pick,
// RAM read and update, a scan of all slots for the next deadline and the
// report. A tick repeats due scan, update, deadline scan and report once per
// expiry, up to 16 expiries, with busy high throughout. Slots are read one at
// a time through the read address shared by both RAMs.
// Reset clears valid bits, the expiry count and the sequencer. Results
// cannot be stalled.
module multi_timer_scheduler_core
	import mts_pkg::*;
#(
	parameter int TIMERS = TIMERS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  mts_pkg::req_t req,
	output logic          rsp_valid,
	output mts_pkg::rsp_t rsp
);
	localparam int AW = (TIMERS > 1) ? $clog2(TIMERS) : 1;
	localparam int CW = $clog2(TIMERS + 2);
	localparam int EW = $clog2(17);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SCAN = 3'd1;
	localparam logic [2:0] S_ACT  = 3'd2;
	localparam logic [2:0] S_NEXT = 3'd3;
	localparam logic [2:0] S_OUT  = 3'd4;

	logic [2:0] state_q;
	req_t req_q;
	logic [TIMERS-1:0] valid_q, handled_q;
	logic [31:0] count_q;
	logic [CW-1:0] idx_q;
	logic [EW-1:0] nev_q;
	logic rd_ok_s1;
	logic [AW-1:0] rd_idx_s1;
	logic found_q;
	logic more_q;
	logic [AW-1:0] pick_q;
	logic [TW-1:0] best_q, pick_dl_q, pick_per_q;
	logic [2:0] st_q;
	logic [3:0] so_q;
	logic re_q;

	logic we;
	logic [AW-1:0] waddr, raddr;
	logic [TW-1:0] dl_wdata, dl_rdata, per_rdata;
	logic per_we;

	mts_ram #(.WIDTH(TW), .DEPTH(TIMERS), .AW(AW)) u_dl (
		.clk(clk), .we(we), .waddr(waddr), .wdata(dl_wdata),
		.raddr(raddr), .rdata(dl_rdata));
	mts_ram #(.WIDTH(TW), .DEPTH(TIMERS), .AW(AW)) u_per (
		.clk(clk), .we(per_we), .waddr(waddr), .wdata(req_q.reload_interval),
		.raddr(raddr), .rdata(per_rdata));

	assign busy = (state_q != S_IDLE);
	assign raddr = (state_q == S_ACT) ? pick_q : idx_q[AW-1:0];

	logic slot_ok;
	assign slot_ok = (32'(req_q.slot) < 32'(TIMERS)) && valid_q[AW'(req_q.slot)];

	// candidate test for the slot read in the previous cycle
	logic cand;
	always_comb begin
		cand = 1'b0;
		if (rd_ok_s1 && valid_q[rd_idx_s1]) begin
			if (state_q == S_NEXT) cand = 1'b1;
			else if (!handled_q[rd_idx_s1] && dl_rdata <= req_q.now_us) cand = 1'b1;
		end
	end

	// flag a valid, not yet handled slot that is still due
	logic due;
	assign due = rd_ok_s1 && valid_q[rd_idx_s1] && !handled_q[rd_idx_s1] &&
		(dl_rdata <= req_q.now_us);

	// write and result computation for the action step
	logic [TW-1:0] fire_dl;
	logic [TW-1:0] ahead_dl;
	logic ahead_exp;
	always_comb begin
		fire_dl   = sat_add(req_q.now_us, per_rdata);
		ahead_dl  = dl_rdata - req_q.time_amount;
		ahead_exp = (req_q.time_amount > dl_rdata) || (ahead_dl < req_q.now_us);
		we = 1'b0;
		per_we = 1'b0;
		waddr = pick_q;
		dl_wdata = fire_dl;
		if (state_q == S_ACT && rd_ok_s1) begin
			unique case (req_q.op)
				OP_TICK: we = found_q && (per_rdata != '0);
				OP_ADD: begin
					we = found_q; per_we = found_q;
					dl_wdata = sat_add(req_q.now_us, req_q.time_amount);
				end
				OP_CHANGE: begin
					we = slot_ok; dl_wdata = sat_add(req_q.now_us, req_q.time_amount);
				end
				OP_AHEAD: begin
					we = slot_ok && (!ahead_exp || per_rdata != '0);
					dl_wdata = ahead_exp ? fire_dl : ahead_dl;
				end
				OP_DELAY: begin
					we = slot_ok; dl_wdata = sat_add(dl_rdata, req_q.time_amount);
				end
				OP_EXPIRE: we = slot_ok && (per_rdata != '0);
				default: we = 1'b0;
			endcase
		end
	end

	// sequencer: scan, act, scan for next deadline, report
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			valid_q <= '0;
			count_q <= '0;
			rsp_valid <= 1'b0;
			rd_ok_s1 <= 1'b0;
			found_q <= 1'b0;
			more_q <= 1'b0;
			handled_q <= '0;
			idx_q <= '0;
			nev_q <= '0;
		end else begin
			rsp_valid <= 1'b0;
			rd_ok_s1 <= 1'b0;
			rd_idx_s1 <= idx_q[AW-1:0];
			unique case (state_q)
				S_IDLE: if (start) begin
					req_q <= req;
					handled_q <= '0;
					nev_q <= '0;
					idx_q <= '0;
					found_q <= 1'b0;
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					// pick earliest due slot (tick) or lowest free slot (add)
					if (req_q.op == OP_TICK) begin
						if (idx_q < CW'(TIMERS)) begin
							rd_ok_s1 <= 1'b1;
							idx_q <= idx_q + 1'b1;
						end
						if (cand && (!found_q || dl_rdata < pick_dl_q)) begin
							found_q <= 1'b1; pick_q <= rd_idx_s1; pick_dl_q <= dl_rdata;
						end
						if (idx_q == CW'(TIMERS) && !rd_ok_s1) state_q <= S_ACT;
					end else begin
						found_q <= 1'b0;
						pick_q <= AW'(req_q.slot);
						if (req_q.op == OP_ADD) begin
							for (int i = TIMERS - 1; i >= 0; i--)
								if (!valid_q[i]) begin
									found_q <= 1'b1; pick_q <= AW'(i);
								end
						end
						state_q <= S_ACT;
					end
				end
				S_ACT: begin
					// wait for registered read data of the picked slot, then apply the request
					if (!rd_ok_s1) begin
						rd_ok_s1 <= 1'b1;
						idx_q <= '0;
					end else begin
						re_q <= 1'b0;
						st_q <= ST_DONE;
						so_q <= 4'(pick_q);
						unique case (req_q.op)
							OP_TICK: if (found_q) begin
								handled_q[pick_q] <= 1'b1;
								count_q <= count_q + 1'b1;
								st_q <= ST_EXPIRED;
								re_q <= (per_rdata != '0);
								if (per_rdata == '0) valid_q[pick_q] <= 1'b0;
								nev_q <= nev_q + 1'b1;
							end else begin
								st_q <= ST_NONE; so_q <= '0;
							end
							OP_ADD: if (found_q) valid_q[pick_q] <= 1'b1;
								else begin st_q <= ST_FULL; so_q <= '0; end
							OP_CHANGE, OP_DELAY: if (!slot_ok) begin
								st_q <= ST_NOSLOT; so_q <= req_q.slot;
							end else so_q <= req_q.slot;
							OP_CANCEL: begin
								so_q <= req_q.slot;
								if (slot_ok) valid_q[pick_q] <= 1'b0;
								else st_q <= ST_NOSLOT;
							end
							OP_AHEAD, OP_EXPIRE: begin
								so_q <= req_q.slot;
								if (!slot_ok) st_q <= ST_NOSLOT;
								else if (req_q.op == OP_EXPIRE || ahead_exp) begin
									st_q <= ST_EXPIRED;
									re_q <= (per_rdata != '0);
									if (per_rdata == '0) valid_q[pick_q] <= 1'b0;
								end
							end
							default: so_q <= '0;
						endcase
						idx_q <= '0;
						found_q <= 1'b0;
						more_q <= 1'b0;
						state_q <= S_NEXT;
					end
				end
				S_NEXT: begin
					// minimum deadline over valid slots after the update
					if (idx_q < CW'(TIMERS)) begin
						rd_ok_s1 <= 1'b1;
						idx_q <= idx_q + 1'b1;
					end
					if (cand && (!found_q || dl_rdata < best_q)) begin
						found_q <= 1'b1; best_q <= dl_rdata;
					end
					if (due) more_q <= 1'b1;
					if (idx_q == CW'(TIMERS) && !rd_ok_s1) state_q <= S_OUT;
				end
				S_OUT: begin
					rsp_valid <= 1'b1;
					rsp.status <= st_q;
					rsp.slot_out <= so_q;
					rsp.rearmed <= re_q;
					rsp.next_deadline <= found_q ? best_q : '0;
					rsp.expire_total <= count_q;
					idx_q <= '0;
					found_q <= 1'b0;
					// continue the tick while another timer is due, up to 16 expiries
					if (st_q == ST_EXPIRED && req_q.op == OP_TICK && nev_q < EW'(16) &&
							more_q) begin
						rsp.last <= 1'b0;
						state_q <= S_SCAN;
					end else begin
						rsp.last <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_busy_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.last |-> $past(state_q) == S_OUT) else $error("result out of order");
	a_no_strobe_idle: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> $past(busy)) else $error("result without request");
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != $past(count_q) |-> $past(req_q.op) == OP_TICK) else $error("count moved");
`endif
endmodule
